// ===== src/ptr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ptr_pkg;

   localparam int HISTORY_DEPTH = 8;

   localparam int SAMPLE_W = 16;
   localparam int VOLT_W   = 8;
   localparam int M_W      = 12;
   localparam int DIFF_W   = 13;
   localparam int VAL_W    = 18;
   localparam int GAIN_W   = 8;
   localparam int PROD_W   = VAL_W + GAIN_W + 1;
   localparam int TEMP_W   = 11;
   localparam int MAG_W    = 15;
   localparam int ACC_W    = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   localparam int ROUND_BIAS  = 16;
   localparam int ROUND_SHIFT = 5;
   localparam int KELVIN_OFS  = 275;
   localparam int DEADBAND    = 3;
   localparam int GAIN_SHIFT  = 7;
   localparam int MAG_MAX     = 32767;

   localparam logic [7:0] CEILING_RST  = 8'd45;
   localparam logic [7:0] CAL_RST      = 8'd0;
   localparam logic [7:0] VLOW_RST     = 8'd29;
   localparam logic [3:0] LOOKAHEAD_RST = 4'd4;
   localparam logic [7:0] GAIN_RST     = 8'd64;
   localparam logic [6:0] SPACING_RST  = 7'd24;

   localparam logic [CSR_IDX_W-1:0] CSR_CEILING   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VLOW      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOKAHEAD = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SPACING   = 3'd5;

   typedef enum logic [1:0] {
      EV_NONE = 2'd0,
      EV_HOT  = 2'd1,
      EV_COLD = 2'd2,
      EV_OKAY = 2'd3
   } event_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'd0,
      ST_DIFF = 3'd1,
      ST_PRED = 3'd2,
      ST_ERR  = 3'd3,
      ST_MAG  = 3'd4,
      ST_DONE = 3'd5
   } state_type;

   typedef struct packed {
      logic           rd_en;
      logic           wr_en;
      logic           fill_en;
      logic [M_W-1:0] data;
   } hist_ctl_type;

endpackage

`default_nettype wire

// ===== src/ptr_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ptr_req_if;
   logic                            valid;
   logic                            ready;
   logic [ptr_pkg::SAMPLE_W-1:0]    smoothed_sample;
   logic [ptr_pkg::SAMPLE_W-1:0]    raw_sample;
   logic                            restart;
   logic [ptr_pkg::VOLT_W-1:0]      battery_voltage;

   modport source (output valid, smoothed_sample, raw_sample, restart, battery_voltage,
                   input ready);
   modport sink (input valid, smoothed_sample, raw_sample, restart, battery_voltage,
                 output ready);
endinterface

interface ptr_rsp_if;
   logic                            valid;
   logic                            ready;
   logic signed [ptr_pkg::TEMP_W-1:0] temperature_c;
   logic [1:0]                      event_kind;
   logic [ptr_pkg::MAG_W-1:0]       magnitude;

   modport source (output valid, temperature_c, event_kind, magnitude, input ready);
   modport sink (input valid, temperature_c, event_kind, magnitude, output ready);
endinterface

`default_nettype wire

// ===== src/ptr_history.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ptr_history #(
   parameter int DEPTH  = ptr_pkg::HISTORY_DEPTH,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire ptr_pkg::hist_ctl_type   ctl,
   input  wire [ADDR_W-1:0]             addr,
   output logic [ptr_pkg::M_W-1:0]      rd_data
);

   logic [ptr_pkg::M_W-1:0] mem [DEPTH];
   logic [ptr_pkg::M_W-1:0] rd_data_ff;
   logic                    rd_valid_ff;
   logic [DEPTH-1:0]        valid_ff;
   logic [ptr_pkg::M_W-1:0] fill_ff;

   // entries not written since the last refill read as the refill value
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[addr] <= ctl.data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         fill_ff     <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (ctl.fill_en) begin
            valid_ff <= '0;
            fill_ff  <= ctl.data;
         end else if (ctl.wr_en) begin
            valid_ff[addr] <= 1'b1;
         end
         if (ctl.rd_en) begin
            rd_valid_ff <= valid_ff[addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : fill_ff;

endmodule

`default_nettype wire

// ===== src/ptr_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ptr_mul (
   input  wire                                  clock,
   input  wire                                  en,
   input  wire signed [ptr_pkg::VAL_W-1:0]      op_a,
   input  wire [ptr_pkg::GAIN_W-1:0]            op_b,
   output logic signed [ptr_pkg::PROD_W-1:0]    prod
);

   logic signed [ptr_pkg::PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= op_a * $signed({1'b0, op_b});
      end
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

// ===== src/predictive_thermal_regulator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An accepted req transaction steps through ST_DIFF, ST_PRED, ST_ERR, ST_MAG
// and ST_DONE, which loads the rsp register; a new req is taken only in ST_IDLE.
// The shared multiplier is used twice per tick (trend prediction, then response
// magnitude) under the sequencer. Output stall holds the result in ST_DONE until
// the rsp register frees. Reset (synchronous, active high): registers to defaults,
// history reads as zero, slot and warning accumulator zero, no result pending.

module predictive_thermal_regulator #(
   parameter int HISTORY_DEPTH = ptr_pkg::HISTORY_DEPTH
) (
   input  wire                               clock,
   input  wire                               reset,
   ptr_req_if.sink                           req,
   ptr_rsp_if.source                         rsp,
   input  wire                               csr_wr_en,
   input  wire [ptr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire [ptr_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int VW = ptr_pkg::VAL_W;

   ptr_pkg::state_type state_ff, state_in;

   logic [7:0]        ceiling_ff;
   logic signed [7:0] cal_ff;
   logic [7:0]        vlow_ff;
   logic [3:0]        lookahead_ff;
   logic [7:0]        gain_ff;
   logic [6:0]        spacing_ff;

   logic [SLOT_W-1:0]                 slot_ff, slot_in;
   logic [ptr_pkg::ACC_W-1:0]         acc_ff, acc_in;
   logic [ptr_pkg::M_W-1:0]           m_ff, m_in;
   logic                              restart_ff, restart_in;
   logic [ptr_pkg::VOLT_W-1:0]        volts_ff, volts_in;
   logic signed [ptr_pkg::DIFF_W-1:0] diff_ff, diff_in;
   logic signed [VW-1:0]              err_ff, err_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [ptr_pkg::TEMP_W-1:0] temp_ff, temp_in;
   ptr_pkg::event_kind_type           kind_ff, kind_in;
   logic [ptr_pkg::MAG_W-1:0]         mag_ff, mag_in;

   ptr_pkg::hist_ctl_type             hist_ctl;
   logic [ptr_pkg::M_W-1:0]           hist_rd;
   logic                              mul_en;
   logic signed [VW-1:0]              mul_a;
   logic [ptr_pkg::GAIN_W-1:0]        mul_b;
   logic signed [ptr_pkg::PROD_W-1:0] prod;

   logic                              accept, out_free, load;
   logic [ptr_pkg::SAMPLE_W:0]        round_sum;
   logic signed [VW-1:0]              ceil_units, pred, err_raw, below, num, how_raw;
   logic [ptr_pkg::MAG_W-1:0]         how;
   logic signed [ptr_pkg::DIFF_W-1:0] temp_wide;
   logic                              acc_pos, acc_neg;

   ptr_history #(
      .DEPTH  (HISTORY_DEPTH),
      .ADDR_W (SLOT_W)
   ) u_history (
      .clock   (clock),
      .reset   (reset),
      .ctl     (hist_ctl),
      .addr    (slot_ff),
      .rd_data (hist_rd)
   );

   ptr_mul u_mul (
      .clock (clock),
      .en    (mul_en),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   assign accept   = req.valid && req.ready;
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == ptr_pkg::ST_IDLE);

   assign round_sum = (req.restart ? {1'b0, req.raw_sample} : {1'b0, req.smoothed_sample})
                      + (ptr_pkg::SAMPLE_W + 1)'(ptr_pkg::ROUND_BIAS);

   assign ceil_units = (VW'($signed({1'b0, ceiling_ff})) + VW'(ptr_pkg::KELVIN_OFS)
                        - VW'(cal_ff)) <<< 1;
   assign pred    = $signed({{(VW - ptr_pkg::M_W){1'b0}}, m_ff}) + prod[VW-1:0];
   assign err_raw = pred - ceil_units;
   assign below   = err_ff + VW'(4);
   assign num     = (err_ff <<< 1) - VW'(ptr_pkg::DEADBAND);
   assign how_raw = VW'(prod >>> ptr_pkg::GAIN_SHIFT);
   assign acc_pos = !acc_ff[ptr_pkg::ACC_W-1] && (acc_ff != '0);
   assign acc_neg = acc_ff[ptr_pkg::ACC_W-1];
   assign temp_wide = $signed({2'b00, m_ff[ptr_pkg::M_W-1:1]})
                      + ptr_pkg::DIFF_W'(cal_ff)
                      - ptr_pkg::DIFF_W'(ptr_pkg::KELVIN_OFS);

   always_comb begin
      if (err_ff > VW'(1)) begin
         if (how_raw < VW'(1)) begin
            how = ptr_pkg::MAG_W'(1);
         end else if (how_raw > VW'(ptr_pkg::MAG_MAX)) begin
            how = ptr_pkg::MAG_W'(ptr_pkg::MAG_MAX);
         end else begin
            how = how_raw[ptr_pkg::MAG_W-1:0];
         end
      end else begin
         how = ptr_pkg::MAG_W'(1);
      end
   end

   always_comb begin
      state_in     = state_ff;
      hist_ctl     = '0;
      hist_ctl.data = m_ff;
      mul_en       = 1'b0;
      mul_a        = VW'(diff_ff);
      mul_b        = {4'b0000, lookahead_ff};
      load         = 1'b0;
      slot_in      = slot_ff;
      m_in         = m_ff;
      restart_in   = restart_ff;
      volts_in     = volts_ff;
      diff_in      = diff_ff;
      err_in       = err_ff;
      acc_in       = acc_ff;
      temp_in      = temp_ff;
      kind_in      = kind_ff;
      mag_in       = mag_ff;
      unique case (state_ff)
         ptr_pkg::ST_IDLE: begin
            if (accept) begin
               hist_ctl.rd_en = 1'b1;
               m_in       = round_sum[ptr_pkg::SAMPLE_W:ptr_pkg::ROUND_SHIFT];
               restart_in = req.restart;
               volts_in   = req.battery_voltage;
               state_in   = ptr_pkg::ST_DIFF;
            end
         end
         ptr_pkg::ST_DIFF: begin
            hist_ctl.wr_en   = !restart_ff;
            hist_ctl.fill_en = restart_ff;
            diff_in = restart_ff ? '0 :
                      $signed({1'b0, m_ff}) - $signed({1'b0, hist_rd});
            slot_in = (slot_ff == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
            state_in = ptr_pkg::ST_PRED;
         end
         ptr_pkg::ST_PRED: begin
            mul_en   = 1'b1;
            state_in = ptr_pkg::ST_ERR;
         end
         ptr_pkg::ST_ERR: begin
            if (err_raw > VW'(ptr_pkg::DEADBAND)) begin
               err_in = err_raw - VW'(ptr_pkg::DEADBAND);
            end else if (err_raw < -VW'(ptr_pkg::DEADBAND)) begin
               err_in = err_raw + VW'(ptr_pkg::DEADBAND);
            end else begin
               err_in = '0;
            end
            state_in = ptr_pkg::ST_MAG;
         end
         ptr_pkg::ST_MAG: begin
            mul_en   = 1'b1;
            mul_a    = num;
            mul_b    = gain_ff;
            state_in = ptr_pkg::ST_DONE;
         end
         ptr_pkg::ST_DONE: begin
            if (out_free) begin
               load    = 1'b1;
               temp_in = temp_wide[ptr_pkg::TEMP_W-1:0];
               kind_in = ptr_pkg::EV_NONE;
               mag_in  = '0;
               if (err_ff > VW'(0) && !diff_ff[ptr_pkg::DIFF_W-1]) begin
                  if (acc_pos) begin
                     acc_in = acc_ff - err_ff[ptr_pkg::ACC_W-1:0];
                  end else begin
                     acc_in  = {1'b0, spacing_ff} - how[ptr_pkg::ACC_W-1:0];
                     kind_in = ptr_pkg::EV_HOT;
                     mag_in  = how;
                  end
               end else if (below < VW'(0) && diff_ff[ptr_pkg::DIFF_W-1]) begin
                  if (acc_neg) begin
                     acc_in = acc_ff - below[ptr_pkg::ACC_W-1:0];
                  end else begin
                     acc_in = 8'd0 - {1'b0, spacing_ff} - below[ptr_pkg::ACC_W-1:0];
                     if ({1'b0, volts_ff} > ({1'b0, vlow_ff} + 9'd1)) begin
                        kind_in = ptr_pkg::EV_COLD;
                        mag_in  = ptr_pkg::MAG_W'((-below) >>> 1);
                     end
                  end
               end else if (volts_ff > vlow_ff) begin
                  kind_in = ptr_pkg::EV_OKAY;
               end
               state_in = ptr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ptr_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptr_pkg::ST_IDLE;
         slot_ff      <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff       <= m_in;
      restart_ff <= restart_in;
      volts_ff   <= volts_in;
      diff_ff    <= diff_in;
      err_ff     <= err_in;
      temp_ff    <= temp_in;
      kind_ff    <= kind_in;
      mag_ff     <= mag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ceiling_ff   <= ptr_pkg::CEILING_RST;
         cal_ff       <= ptr_pkg::CAL_RST;
         vlow_ff      <= ptr_pkg::VLOW_RST;
         lookahead_ff <= ptr_pkg::LOOKAHEAD_RST;
         gain_ff      <= ptr_pkg::GAIN_RST;
         spacing_ff   <= ptr_pkg::SPACING_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            ptr_pkg::CSR_CEILING:   ceiling_ff   <= csr_wr_data;
            ptr_pkg::CSR_CAL:       cal_ff       <= csr_wr_data;
            ptr_pkg::CSR_VLOW:      vlow_ff      <= csr_wr_data;
            ptr_pkg::CSR_LOOKAHEAD: lookahead_ff <= csr_wr_data[3:0];
            ptr_pkg::CSR_GAIN:      gain_ff      <= csr_wr_data;
            ptr_pkg::CSR_SPACING:   spacing_ff   <= csr_wr_data[6:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.temperature_c = temp_ff;
   assign rsp.event_kind    = kind_ff;
   assign rsp.magnitude     = mag_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ptr_pkg::ST_DIFF)
      else $error("accepted transaction did not start the sequencer");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= SLOT_W'(HISTORY_DEPTH - 1))
      else $error("history slot out of range");

   a_okay_no_mag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && kind_ff == ptr_pkg::EV_OKAY) |-> mag_ff == '0)
      else $error("okay event with magnitude");

   a_hot_has_mag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && kind_ff == ptr_pkg::EV_HOT) |-> mag_ff != '0)
      else $error("hot event without magnitude");

   a_load_only_free: assert property (@(posedge clock) disable iff (reset)
      load |-> (!rsp_valid_ff || rsp.ready))
      else $error("result overwritten while pending");

endmodule

`default_nettype wire
